// ===== hdl/pfc_pkg.sv =====
// shared types, format codes and coefficients of the pixel format converter
package pfc_pkg;

  localparam logic [1:0] FMT_GREY = 2'd0;
  localparam logic [1:0] FMT_RGB  = 2'd1;
  localparam logic [1:0] FMT_BGRA = 2'd2;
  localparam logic [1:0] FMT_YUYV = 2'd3;

  localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
  localparam logic [1:0] REG_TARGET_FORMAT = 2'd1;

  localparam logic [1:0] SOURCE_FORMAT_RESET = FMT_YUYV;
  localparam logic [1:0] TARGET_FORMAT_RESET = FMT_RGB;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int TERM_W = 20;

  localparam logic signed [10:0] COEF_Y  = 11'sd298;
  localparam logic signed [10:0] COEF_RV = 11'sd409;
  localparam logic signed [10:0] COEF_GU = 11'sd100;
  localparam logic signed [10:0] COEF_GV = 11'sd208;
  localparam logic signed [10:0] COEF_BU = 11'sd516;
  localparam logic signed [9:0]  LUMA_OFFSET   = 10'sd16;
  localparam logic signed [9:0]  CHROMA_OFFSET = 10'sd128;
  localparam logic signed [TERM_W-1:0] ROUND_BIAS = TERM_W'(128);
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef enum logic [2:0] {
    JOB_ONE,
    JOB_TRIPLE,
    JOB_TRIPLE_A,
    JOB_SWAP,
    JOB_YUV_RGB,
    JOB_YUV_BGRA,
    JOB_UNSUP
  } job_kind_t;

  typedef struct packed {
    job_kind_t                kind;
    logic [7:0]               pa;
    logic [7:0]               pb;
    logic [7:0]               pc;
    logic signed [TERM_W-1:0] yt0;
    logic signed [TERM_W-1:0] yt1;
    logic signed [TERM_W-1:0] rt;
    logic signed [TERM_W-1:0] gt;
    logic signed [TERM_W-1:0] bt;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [2:0] job_last(input job_kind_t kind);
    logic [2:0] r;
    unique case (kind)
      JOB_ONE:      r = 3'd0;
      JOB_TRIPLE:   r = 3'd2;
      JOB_TRIPLE_A: r = 3'd3;
      JOB_SWAP:     r = 3'd3;
      JOB_YUV_RGB:  r = 3'd5;
      JOB_YUV_BGRA: r = 3'd7;
      JOB_UNSUP:    r = 3'd0;
      default:      r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/pfc_front.sv =====
// front end: config registers, byte grouping and job classification
module pfc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [1:0]       cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             frame_last,
  input  pfc_pkg::q_status_t q_stat,
  output logic             push,
  output pfc_pkg::job_t    job
);
  import pfc_pkg::*;

  logic [1:0] source_format;
  logic [1:0] target_format;
  logic [1:0] byte_phase;
  logic [7:0] held_bytes [3];

  logic       accept;
  logic       supported;
  logic [2:0] group;
  logic       complete;
  job_kind_t  kind;
  logic [7:0] pa, pb, pc;
  logic signed [9:0] c0, c1, d, e;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_stat.full;
  assign accept    = in_valid && in_ready;

  always_comb begin
    supported = 1'b1;
    group     = 3'd1;
    kind      = JOB_ONE;
    pa        = in_byte;
    pb        = held_bytes[1];
    pc        = held_bytes[0];
    priority if (source_format == target_format) begin
      group = 3'd1;
      kind  = JOB_ONE;
    end else if (source_format == FMT_YUYV && target_format == FMT_GREY) begin
      group = 3'd2;
      kind  = JOB_ONE;
      pa    = held_bytes[0];
    end else if (source_format == FMT_YUYV && target_format == FMT_RGB) begin
      group = 3'd4;
      kind  = JOB_YUV_RGB;
    end else if (source_format == FMT_YUYV && target_format == FMT_BGRA) begin
      group = 3'd4;
      kind  = JOB_YUV_BGRA;
    end else if (source_format == FMT_GREY && target_format == FMT_RGB) begin
      kind = JOB_TRIPLE;
    end else if (source_format == FMT_GREY && target_format == FMT_BGRA) begin
      kind = JOB_TRIPLE_A;
    end else if (source_format == FMT_RGB && target_format == FMT_BGRA) begin
      group = 3'd3;
      kind  = JOB_SWAP;
    end else begin
      supported = 1'b0;
      kind      = JOB_UNSUP;
    end
  end

  assign complete = !supported || (({1'b0, byte_phase} + 3'd1) >= group);
  assign push     = accept && complete;

  // bt.601 product terms
  assign c0 = $signed({2'b00, held_bytes[0]}) - LUMA_OFFSET;
  assign c1 = $signed({2'b00, held_bytes[2]}) - LUMA_OFFSET;
  assign d  = $signed({2'b00, held_bytes[1]}) - CHROMA_OFFSET;
  assign e  = $signed({2'b00, in_byte}) - CHROMA_OFFSET;

  always_comb begin
    job.kind = kind;
    job.pa   = pa;
    job.pb   = pb;
    job.pc   = pc;
    job.yt0  = TERM_W'(c0) * TERM_W'(COEF_Y);
    job.yt1  = TERM_W'(c1) * TERM_W'(COEF_Y);
    job.rt   = TERM_W'(e) * TERM_W'(COEF_RV);
    job.gt   = TERM_W'(0) - TERM_W'(d) * TERM_W'(COEF_GU) - TERM_W'(e) * TERM_W'(COEF_GV);
    job.bt   = TERM_W'(d) * TERM_W'(COEF_BU);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= SOURCE_FORMAT_RESET;
      target_format <= TARGET_FORMAT_RESET;
      byte_phase    <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SOURCE_FORMAT: source_format <= cfg_data;
          REG_TARGET_FORMAT: target_format <= cfg_data;
          default: ;
        endcase
      end
      if (accept && supported) begin
        if (complete || frame_last) byte_phase <= 2'd0;
        else byte_phase <= byte_phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && supported && !complete) begin
      unique case (byte_phase)
        2'd0: held_bytes[0] <= in_byte;
        2'd1: held_bytes[1] <= in_byte;
        2'd2: held_bytes[2] <= in_byte;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/pfc_queue.sv =====
// job queue between front and back
module pfc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pfc_pkg::job_t      push_data,
  input  logic               pop,
  output pfc_pkg::job_t      head,
  output pfc_pkg::q_status_t q_stat
);
  import pfc_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (count == QCNT_W'(QDEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH)) else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> count != QCNT_W'(QDEPTH)) else $error("push into full queue");

endmodule

// ===== hdl/pfc_back.sv =====
// back end: walks each job and emits one output byte per cycle while a job is queued and out_ready allows
module pfc_back (
  input  logic               clk,
  input  logic               rst,
  input  pfc_pkg::job_t      head,
  input  pfc_pkg::q_status_t q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               run_last,
  output logic               unsupported
);
  import pfc_pkg::*;

  logic [2:0] idx;
  logic [2:0] last_idx;
  logic       fire;
  logic       at_last;
  logic [7:0] byte_val;
  logic       pix;
  logic [1:0] chan;
  logic signed [TERM_W-1:0] ysel, csel, acc;
  logic [7:0] clamped;

  localparam logic [1:0] CH_R = 2'd0;
  localparam logic [1:0] CH_G = 2'd1;
  localparam logic [1:0] CH_B = 2'd2;
  localparam logic [1:0] CH_A = 2'd3;

  assign last_idx = job_last(head.kind);
  assign fire     = !q_stat.empty && (!out_valid || out_ready);
  assign at_last  = (idx == last_idx);
  assign pop      = fire && at_last;

  // pixel and channel of the current byte
  always_comb begin
    if (head.kind == JOB_YUV_RGB) begin
      pix = (idx >= 3'd3);
      unique case (idx)
        3'd0, 3'd3: chan = CH_R;
        3'd1, 3'd4: chan = CH_G;
        default:    chan = CH_B;
      endcase
    end else begin
      pix = idx[2];
      unique case (idx[1:0])
        2'd0:    chan = CH_B;
        2'd1:    chan = CH_G;
        2'd2:    chan = CH_R;
        default: chan = CH_A;
      endcase
    end
  end

  always_comb begin
    ysel = pix ? head.yt1 : head.yt0;
    unique case (chan)
      CH_R:    csel = head.rt;
      CH_G:    csel = head.gt;
      CH_B:    csel = head.bt;
      default: csel = '0;
    endcase
    acc = ysel + csel + ROUND_BIAS;
    if (acc < 0) clamped = 8'd0;
    else if (acc[TERM_W-1:16] != '0) clamped = 8'd255;
    else clamped = acc[15:8];
  end

  always_comb begin
    unique case (head.kind)
      JOB_ONE:      byte_val = head.pa;
      JOB_TRIPLE:   byte_val = head.pa;
      JOB_TRIPLE_A: byte_val = (idx == 3'd3) ? ALPHA_OPAQUE : head.pa;
      JOB_SWAP: begin
        unique case (idx[1:0])
          2'd0:    byte_val = head.pa;
          2'd1:    byte_val = head.pb;
          2'd2:    byte_val = head.pc;
          default: byte_val = ALPHA_OPAQUE;
        endcase
      end
      JOB_YUV_RGB:  byte_val = clamped;
      JOB_YUV_BGRA: byte_val = (chan == CH_A) ? ALPHA_OPAQUE : clamped;
      JOB_UNSUP:    byte_val = 8'd0;
      default:      byte_val = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        out_valid   <= 1'b1;
        out_byte    <= byte_val;
        run_last    <= at_last;
        unsupported <= (head.kind == JOB_UNSUP);
        idx         <= at_last ? 3'd0 : idx + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_unsup_beat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && unsupported) |-> (run_last && out_byte == 8'd0))
    else $error("unsupported beat malformed");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    !q_stat.empty |-> idx <= last_idx) else $error("byte index past end of job");

endmodule

// ===== hdl/pixel_format_converter.sv =====
// top level of the pixel format converter
//
//  channel  handshake             payload
//  cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
//  in       in_valid/in_ready     in_byte, frame_last
//  out      out_valid/out_ready   out_byte, run_last, unsupported
//
//  an input byte is taken every cycle while the four-entry job queue has room
//  the back end emits one output byte per cycle while out_ready allows, and
//  an input causes up to 8 output bytes per yuyv group, 2 per input byte
//  a completing input is written into the job queue; its first output beat is registered from the queue head
//  rst is synchronous; cfg_ready is always high
//  out_ready low stalls the back end; the queue then fills and drops in_ready
module pixel_format_converter (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       frame_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       unsupported
);
  import pfc_pkg::*;

  q_status_t q_stat;
  job_t      push_job;
  job_t      head;
  logic      push;
  logic      pop;

  pfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .frame_last (frame_last),
    .q_stat     (q_stat),
    .push       (push),
    .job        (push_job)
  );

  pfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  pfc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .unsupported (unsupported)
  );

endmodule

// ===== tb/sv/tb_pixel_format_converter.sv =====
// self-checking testbench for the pixel format converter
`timescale 1ns / 1ps

module tb_pixel_format_converter;
  import pfc_pkg::*;

  localparam int          SETTLE_CYCLES = 20;
  localparam int          STUCK_LIMIT   = 2000;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          RANDOM_PHASES = 6;
  localparam int          PHASE_BYTES   = 6;
  localparam int          PRESSURE_PHASE = 2;
  localparam logic [1:0]  REG_SPARE_A   = 2'd2;
  localparam logic [1:0]  REG_SPARE_B   = 2'd3;
  localparam logic [7:0]  OPAQUE        = 8'hFF;

  typedef struct {
    logic [7:0] data;
    logic       fl;
  } src_beat_t;

  typedef struct {
    logic [7:0] data;
    logic       run_last;
    logic       unsupported;
  } out_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = 2'd0;
  logic [1:0] cfg_data = 2'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'd0;
  logic       frame_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;
  logic       unsupported;

  src_beat_t   frame_bytes[$];
  out_beat_t   bytes_due[$];
  src_beat_t   next_beat;
  out_beat_t   want_beat;

  logic [1:0]  cur_src = FMT_YUYV;
  logic [1:0]  cur_dst = FMT_RGB;
  logic [1:0]  phase = 2'd0;
  logic [7:0]  held[3] = '{8'd0, 8'd0, 8'd0};

  int unsigned bytes_pushed = 0;
  int unsigned in_beats = 0;
  int unsigned cfg_beats = 0;
  int unsigned fail_count = 0;
  int unsigned stuck_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned stall_draw = 0;
  int unsigned hold_left = 0;
  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  bit          send_idle = 1'b0;
  bit          recv_idle = 1'b0;
  bit          hold_request = 1'b0;
  bit          hold_started = 1'b0;

  pixel_format_converter uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .frame_last  (frame_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .unsupported (unsupported)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int group_size(logic [1:0] s, logic [1:0] d);
    if (s == d) return 1;
    if (s == FMT_YUYV && d == FMT_GREY) return 2;
    if (s == FMT_YUYV && (d == FMT_RGB || d == FMT_BGRA)) return 4;
    if (s == FMT_GREY && (d == FMT_RGB || d == FMT_BGRA)) return 1;
    if (s == FMT_RGB && d == FMT_BGRA) return 3;
    return 0;
  endfunction

  function automatic logic [7:0] clamp_channel(int acc);
    int v;
    v = acc >>> 8;
    if (v > 255) v = 255;
    else if (v < 0) v = 0;
    return v[7:0];
  endfunction

  function automatic void yuv_to_rgb(input logic [7:0] y, u, v,
                                     output logic [7:0] r, g, b);
    int c;
    int dd;
    int e;
    c = int'(y) - 16;
    dd = int'(u) - 128;
    e = int'(v) - 128;
    r = clamp_channel(298 * c + 409 * e + 128);
    g = clamp_channel(298 * c - 100 * dd - 208 * e + 128);
    b = clamp_channel(298 * c + 516 * dd + 128);
  endfunction

  // works out the output bytes caused by one accepted input byte
  function automatic void convert_byte(logic [7:0] din, logic fl);
    int gs;
    logic [7:0] emit[$];
    logic [7:0] r0, g0, b0, r1, g1, b1;
    out_beat_t ob;
    gs = group_size(cur_src, cur_dst);
    if (gs == 0) begin
      ob.data = 8'd0;
      ob.run_last = 1'b1;
      ob.unsupported = 1'b1;
      bytes_due.push_back(ob);
      return;
    end
    if (int'(phase) + 1 < gs) begin
      held[phase] = din;
      phase = fl ? 2'd0 : phase + 2'd1;
      return;
    end
    if (cur_src == cur_dst) begin
      emit.push_back(din);
    end else if (gs == 2) begin
      emit.push_back(held[0]);
    end else if (cur_src == FMT_GREY) begin
      emit.push_back(din);
      emit.push_back(din);
      emit.push_back(din);
      if (cur_dst == FMT_BGRA) emit.push_back(OPAQUE);
    end else if (gs == 3) begin
      emit.push_back(din);
      emit.push_back(held[1]);
      emit.push_back(held[0]);
      emit.push_back(OPAQUE);
    end else begin
      yuv_to_rgb(held[0], held[1], din, r0, g0, b0);
      yuv_to_rgb(held[2], held[1], din, r1, g1, b1);
      if (cur_dst == FMT_RGB) begin
        emit.push_back(r0);
        emit.push_back(g0);
        emit.push_back(b0);
        emit.push_back(r1);
        emit.push_back(g1);
        emit.push_back(b1);
      end else begin
        emit.push_back(b0);
        emit.push_back(g0);
        emit.push_back(r0);
        emit.push_back(OPAQUE);
        emit.push_back(b1);
        emit.push_back(g1);
        emit.push_back(r1);
        emit.push_back(OPAQUE);
      end
    end
    foreach (emit[k]) begin
      ob.data = emit[k];
      ob.run_last = (k == emit.size() - 1);
      ob.unsupported = 1'b0;
      bytes_due.push_back(ob);
    end
    phase = 2'd0;
  endfunction

  task automatic push_byte(logic [7:0] d, logic fl);
    src_beat_t sb;
    sb.data = d;
    sb.fl = fl;
    frame_bytes.push_back(sb);
    bytes_pushed++;
  endtask

  task automatic drain();
    do @(negedge clk); while (in_beats != bytes_pushed || bytes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [1:0] val);
    int unsigned seen;
    seen = cfg_beats;
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (cfg_beats == seen);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic reconfig(logic [1:0] s, logic [1:0] d, bit spare);
    drain();
    write_reg(REG_SOURCE_FORMAT, s);
    write_reg(REG_TARGET_FORMAT, d);
    if (spare) begin
      write_reg(REG_SPARE_A, ~s);
      write_reg(REG_SPARE_B, ~d);
    end
    @(posedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_taken) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (frame_bytes.size() != 0) begin
        next_beat = frame_bytes.pop_front();
        in_valid <= 1'b1;
        in_byte <= next_beat.data;
        frame_last <= next_beat.fl;
        send_gap <= send_idle ? $urandom_range(0, 15) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output receiver
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall <= 0;
      hold_left <= 0;
    end else if (hold_request && !hold_started) begin
      hold_started <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (out_taken) begin
      stall_draw = recv_idle ? $urandom_range(0, 15) : 0;
      out_ready <= (stall_draw == 0);
      recv_stall <= (stall_draw == 0) ? 0 : stall_draw - 1;
    end else if (recv_stall != 0) begin
      recv_stall <= recv_stall - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SOURCE_FORMAT: cur_src = cfg_data;
          REG_TARGET_FORMAT: cur_dst = cfg_data;
          default: ;
        endcase
        cfg_beats <= cfg_beats + 1;
      end
      if (in_valid && in_ready) begin
        convert_byte(in_byte, frame_last);
        in_beats <= in_beats + 1;
      end
      if (out_valid && out_ready) begin
        if (bytes_due.size() == 0) begin
          $error("out_byte %0d arrived with no beat expected", out_byte);
          fail_count++;
        end else begin
          want_beat = bytes_due.pop_front();
          if (out_byte !== want_beat.data) begin
            $error("out_byte mismatch: expected %0d, actual %0d", want_beat.data, out_byte);
            fail_count++;
          end
          if (run_last !== want_beat.run_last) begin
            $error("run_last mismatch: expected %0d, actual %0d",
                   want_beat.run_last, run_last);
            fail_count++;
          end
          if (unsupported !== want_beat.unsupported) begin
            $error("unsupported mismatch: expected %0d, actual %0d",
                   want_beat.unsupported, unsupported);
            fail_count++;
          end
        end
      end
    end
    in_taken <= !rst && in_valid && in_ready;
    out_taken <= !rst && out_valid && out_ready;
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int gs;
    int count;
    int groups;
    int cut;
    logic [1:0] s;
    logic [1:0] d;
    logic fl;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset formats: yuyv to rgb, with clamping at both ends
    push_byte(8'd0, 1'b0);
    push_byte(8'd0, 1'b0);
    push_byte(8'd255, 1'b0);
    push_byte(8'd255, 1'b0);
    push_byte(8'd16, 1'b0);
    push_byte(8'd128, 1'b0);
    push_byte(8'd235, 1'b0);
    push_byte(8'd128, 1'b0);
    // partial group dropped at frame end
    push_byte(8'd255, 1'b0);
    push_byte(8'd0, 1'b1);

    reconfig(FMT_YUYV, FMT_BGRA, 1'b0);
    push_byte(8'd81, 1'b0);
    push_byte(8'd90, 1'b0);
    push_byte(8'd145, 1'b0);
    push_byte(8'd240, 1'b1);

    reconfig(FMT_YUYV, FMT_GREY, 1'b0);
    push_byte(8'd200, 1'b0);
    push_byte(8'd55, 1'b0);
    push_byte(8'd77, 1'b0);

    // format change with a byte still held
    reconfig(FMT_YUYV, FMT_YUYV, 1'b0);
    push_byte(8'd255, 1'b0);

    reconfig(FMT_GREY, FMT_RGB, 1'b0);
    push_byte(8'd0, 1'b0);
    reconfig(FMT_GREY, FMT_BGRA, 1'b0);
    push_byte(8'd255, 1'b0);
    reconfig(FMT_GREY, FMT_GREY, 1'b0);
    push_byte(8'd128, 1'b1);

    reconfig(FMT_RGB, FMT_BGRA, 1'b0);
    push_byte(8'd0, 1'b0);
    push_byte(8'd255, 1'b0);
    push_byte(8'd170, 1'b1);

    reconfig(FMT_BGRA, FMT_RGB, 1'b1);
    push_byte(8'd85, 1'b1);
    push_byte(8'd170, 1'b0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == PRESSURE_PHASE) begin
        reconfig(FMT_YUYV, FMT_BGRA, 1'b0);
        send_idle = 1'b0;
        recv_idle = 1'b1;
        hold_request = 1'b1;
        for (int k = 0; k < 32; k++) push_byte(8'($urandom_range(0, 255)), k == 31);
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 4))
            0: begin s = FMT_YUYV; d = FMT_RGB; end
            1: begin s = FMT_YUYV; d = FMT_BGRA; end
            2: begin s = FMT_YUYV; d = FMT_GREY; end
            3: begin s = FMT_RGB; d = FMT_BGRA; end
            default: begin s = FMT_GREY; d = 2'($urandom_range(0, 3)); end
          endcase
        end else begin
          s = 2'($urandom_range(0, 3));
          d = 2'($urandom_range(0, 3));
        end
        reconfig(s, d, $urandom_range(0, 3) == 0);
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
        gs = group_size(s, d);
        count = 0;
        while (count < PHASE_BYTES) begin
          if (gs == 0) begin
            push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            count++;
          end else begin
            groups = $urandom_range(1, 3);
            for (int g = 0; g < groups; g++) begin
              // now and then a group cut short by frame end
              cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, gs) : gs;
              for (int k = 0; k < cut; k++) begin
                fl = (k == cut - 1) && (cut < gs || g == groups - 1);
                push_byte(8'($urandom_range(0, 255)), fl);
                count++;
              end
              if (cut < gs) break;
            end
          end
        end
        // stray byte, left held across the next format change where a group spans several bytes
        if ($urandom_range(0, 3) == 0) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
